@@ hw/rtl/oota_pkg.sv @@
// Shared types and codes for the overcurrent / overtemperature alarm qualifier.
// Used by oota_eval and the top level; no dependencies.
package oota_pkg;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_WARN = 2'd1,
    LVL_CRIT = 2'd2
  } level_t;

  typedef enum logic {
    CAUSE_CURRENT = 1'b0,
    CAUSE_TEMP    = 1'b1
  } cause_t;

  typedef enum logic [1:0] {
    REG_WARN_CURRENT  = 2'd0,
    REG_ALARM_CURRENT = 2'd1,
    REG_TEMP_ALARM    = 2'd2,
    REG_HOLD_TIME     = 2'd3
  } reg_index_t;

  localparam int unsigned CurW  = 19;
  localparam int unsigned TempW = 12;
  localparam int unsigned TlimW = 11;
  localparam int unsigned HoldW = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [CurW-1:0]  WarnCurrentRst = 19'd8000;
  localparam logic [CurW-1:0]  AlarmCurrentRst = 19'd12000;
  localparam logic [TlimW-1:0] TempAlarmRst    = 11'd800;
  localparam logic [HoldW-1:0] HoldTimeRst     = 16'd500;

  typedef struct packed {
    logic [CurW-1:0]  warn_current_ma;
    logic [CurW-1:0]  alarm_current_ma;
    logic [TlimW-1:0] temp_alarm_decic;
    logic [HoldW-1:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [TempW-1:0] temp_two_decic;
    logic [TempW-1:0] temp_one_decic;
    logic [CurW-1:0]  current_ma;
  } in_item_t;

  typedef struct packed {
    logic [TimeW-1:0] record_time_ms;
    logic [CurW-1:0]  limit_value;
    logic [CurW-1:0]  trip_value;
    cause_t           alarm_cause;
    logic             level_changed;
    level_t           alarm_level;
    logic             record_valid;
  } out_item_t;

endpackage

@@ hw/rtl/oota_eval.sv @@
// Alarm evaluation: hold timers, previous level and the result of one sample.
// Depends on oota_pkg.
module oota_eval
  import oota_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  level_t           previous_level;
  logic             alarm_timing;
  logic [TimeW-1:0] alarm_start_time;
  logic             warn_timing;
  logic [TimeW-1:0] warn_start_time;

  logic             alarm_timing_next;
  logic [TimeW-1:0] alarm_start_time_next;
  logic             warn_timing_next;
  logic [TimeW-1:0] warn_start_time_next;

  logic             cur_ge_alarm;
  logic             cur_ge_warn;
  logic [TimeW-1:0] alarm_elapsed;
  logic [TimeW-1:0] warn_elapsed;
  logic             crit;
  logic             warn;
  logic signed [TempW-1:0] tmax;
  logic             temp_hot;
  level_t           level;

  always_comb begin
    cur_ge_alarm = $signed(item.current_ma) >= $signed(cfg.alarm_current_ma);
    cur_ge_warn  = $signed(item.current_ma) >= $signed(cfg.warn_current_ma);

    // a timer that is not running starts now, so its elapsed time is zero
    alarm_elapsed = alarm_timing ? (item.time_ms - alarm_start_time) : '0;
    warn_elapsed  = warn_timing ? (item.time_ms - warn_start_time) : '0;

    crit = cur_ge_alarm && (alarm_elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.hold_time_ms});
    warn = !crit && cur_ge_warn &&
           (warn_elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.hold_time_ms});

    alarm_timing_next     = cur_ge_alarm;
    alarm_start_time_next = (cur_ge_alarm && !alarm_timing) ? item.time_ms : alarm_start_time;

    // leave the warning timer alone while critical current qualifies
    warn_timing_next     = warn_timing;
    warn_start_time_next = warn_start_time;
    if (!crit) begin
      warn_timing_next = cur_ge_warn;
      if (cur_ge_warn && !warn_timing) begin
        warn_start_time_next = item.time_ms;
      end
    end

    tmax = ($signed(item.temp_one_decic) > $signed(item.temp_two_decic)) ?
           $signed(item.temp_one_decic) : $signed(item.temp_two_decic);
    temp_hot = $signed({tmax[TempW-1], tmax}) >=
               $signed({2'b00, cfg.temp_alarm_decic});

    if (crit || temp_hot) begin
      level = LVL_CRIT;
    end else if (warn) begin
      level = LVL_WARN;
    end else begin
      level = LVL_NONE;
    end

    res                = '0;
    res.alarm_level    = level;
    res.level_changed  = (level != previous_level);
    res.alarm_cause    = CAUSE_CURRENT;
    if ((level != previous_level) && (level != LVL_NONE)) begin
      res.record_valid   = 1'b1;
      res.record_time_ms = item.time_ms;
      if ((level == LVL_CRIT) && temp_hot) begin
        res.alarm_cause = CAUSE_TEMP;
        res.trip_value  = {{(CurW-TempW){tmax[TempW-1]}}, tmax};
        res.limit_value = {{(CurW-TlimW){1'b0}}, cfg.temp_alarm_decic};
      end else begin
        res.trip_value  = item.current_ma;
        res.limit_value = (level == LVL_CRIT) ? cfg.alarm_current_ma
                                              : cfg.warn_current_ma;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level   <= LVL_NONE;
      alarm_timing     <= 1'b0;
      alarm_start_time <= '0;
      warn_timing      <= 1'b0;
      warn_start_time  <= '0;
    end else if (step) begin
      previous_level   <= level;
      alarm_timing     <= alarm_timing_next;
      alarm_start_time <= alarm_start_time_next;
      warn_timing      <= warn_timing_next;
      warn_start_time  <= warn_start_time_next;
    end
  end

endmodule

@@ hw/rtl/overcurrent_overtemp_alarm_qualifier.sv @@
// Top level of the overcurrent / overtemperature alarm qualifier: config
// registers, input word register, output word register. Depends on oota_pkg, oota_eval.
//
//   channel  | direction | handshake          | contents
//   ---------+-----------+--------------------+------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | one sample word
//   m_*      | out       | m_tvalid/m_tready  | one result word, m_tuser = record flag
//   cfg_*    | in        | cfg_wen            | register write, no read-back
//
// A word taken into the input register is evaluated against the hold timers and moved
// into the output register once that is free. One word per cycle is sustained while
// m_tready stays high; a stalled output holds the output register, an empty input
// register still takes one word, then s_tready drops until m_tready returns.
// Reset restores the register defaults, clears the timers and sets the level to none.
module overcurrent_overtemp_alarm_qualifier
  import oota_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [18:0] current_ma, [30:19] temp_one_decic, [42:31] temp_two_decic,
  // [74:43] time_ms, [79:75] zero
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] alarm_level, [2] level_changed, [3] alarm_cause, [22:4] trip_value,
  // [41:23] limit_value, [73:42] record_time_ms, [79:74] zero
  output logic [79:0] m_tdata,
  // [0] record_valid
  output logic [0:0]  m_tuser,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  localparam int unsigned InW  = $bits(in_item_t);
  localparam int unsigned OutW = $bits(out_item_t) - 1;

  cfg_t      cfg;
  in_item_t  in_item;
  logic      in_valid;
  out_item_t out_item;
  out_item_t res;
  logic      advance;
  logic      step;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_current_ma  <= WarnCurrentRst;
      cfg.alarm_current_ma <= AlarmCurrentRst;
      cfg.temp_alarm_decic <= TempAlarmRst;
      cfg.hold_time_ms     <= HoldTimeRst;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_WARN_CURRENT:  cfg.warn_current_ma  <= cfg_data;
        REG_ALARM_CURRENT: cfg.alarm_current_ma <= cfg_data;
        REG_TEMP_ALARM:    cfg.temp_alarm_decic <= cfg_data[TlimW-1:0];
        REG_HOLD_TIME:     cfg.hold_time_ms     <= cfg_data[HoldW-1:0];
        default:           cfg.hold_time_ms     <= cfg.hold_time_ms;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata[InW-1:0]);
    end
  end

  oota_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= res;
    end
  end

  assign m_tdata = {{(80-OutW){1'b0}}, out_item[OutW:1]};
  assign m_tuser = out_item.record_valid;

endmodule
